[rtl/itf_pkg.sv]
`timescale 1ns / 1ps

package itf_pkg;

    // Input item layout in s_tdata, lowest bit first.
    localparam int IN_W        = 96;
    localparam int VALUE_LSB   = 0;
    localparam int FLAGS_LSB   = 64;
    localparam int BASE_LSB    = 71;
    localparam int SIZE_LSB    = 73;
    localparam int WIDTH_LSB   = 75;
    localparam int PREC_LSB    = 82;

    // Flag bit positions.
    localparam int F_ZERO  = 0;
    localparam int F_LEFT  = 1;
    localparam int F_PLUS  = 2;
    localparam int F_SPACE = 3;
    localparam int F_ALT   = 4;
    localparam int F_SGN   = 5;
    localparam int F_UPPER = 6;

    // Radix selector codes; anything else is hexadecimal.
    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;

    // Argument size codes.
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;

    // Digit store: 22 nibbles cover 64 bits in octal, decimal and hex.
    localparam int DIG_N = 22;
    localparam int DIG_W = DIG_N * 4;

    localparam int MAX_FIELD_WIDTH = 64;
    localparam int RESULT_LIMIT    = 64;
    localparam int QDEPTH          = 2;

    // ASCII codes used by the formatter.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;

    // One conversion as handed from the front end to the emitter.
    // Character positions: [0,a) spaces, [a,b) prefix, [b,d) zeros,
    // [d,e) digits from the most significant, [e,f) spaces.
    typedef struct packed {
        logic [DIG_W-1:0] digits;
        logic [7:0]       p0;
        logic [7:0]       p1;
        logic [7:0]       p2;
        logic             upper;
        logic [6:0]       a;
        logic [6:0]       b;
        logic [6:0]       d;
        logic [6:0]       e;
        logic [6:0]       f;
    } t_desc;

    // ASCII text of one digit value.
    function automatic logic [7:0] digit_char(input logic [3:0] dig, input logic up);
        logic [7:0] res;
        if (dig < 4'd10) begin
            res = CH_ZERO + {4'b0, dig};
        end else begin
            res = (up ? CH_UA : CH_LA) + {4'b0, dig} - 8'd10;
        end
        return res;
    endfunction

endpackage

[rtl/itf_front.sv]
`timescale 1ns / 1ps

module itf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [itf_pkg::IN_W-1:0] i_data,
    output logic                 o_push_valid,
    input  logic                 i_push_ready,
    output itf_pkg::t_desc       o_push_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_FIN1 = 3'd3;
    localparam logic [2:0] S_FIN2 = 3'd4;
    localparam logic [2:0] S_PUSH = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_sh, n_sh;
    logic [itf_pkg::DIG_W-1:0] r_dig, n_dig;
    logic [4:0]  r_idx, n_idx;
    logic        r_left, r_zp, r_upper;
    logic [6:0]  r_prec, r_fw;
    logic [1:0]  r_plen;
    logic [7:0]  r_p0, r_p1, r_p2;
    logic [6:0]  r_nd, r_ndt, r_padn;
    itf_pkg::t_desc r_desc;

    // Unpacked input fields.
    logic [63:0] in_value;
    logic [6:0]  in_flags;
    logic [1:0]  in_base;
    logic [1:0]  in_size;
    logic [6:0]  in_fw;
    logic [6:0]  in_prec;

    assign in_value = i_data[itf_pkg::VALUE_LSB +: 64];
    assign in_flags = i_data[itf_pkg::FLAGS_LSB +: 7];
    assign in_base  = i_data[itf_pkg::BASE_LSB +: 2];
    assign in_size  = i_data[itf_pkg::SIZE_LSB +: 2];
    assign in_fw    = i_data[itf_pkg::WIDTH_LSB +: 7];
    assign in_prec  = i_data[itf_pkg::PREC_LSB +: 7];

    logic accept;
    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    // Truncate, extend and take the magnitude of the argument.
    logic [63:0] ext, mag;
    logic        sgn, negative, is_dec, is_oct, is_hex, alt, has_s;
    logic [7:0]  sch, xch;
    logic [1:0]  plen;
    logic [7:0]  p0, p1, p2;

    always_comb begin
        sgn = in_flags[itf_pkg::F_SGN];
        case (in_size)
            itf_pkg::SIZE_8:  ext = {{56{sgn & in_value[7]}}, in_value[7:0]};
            itf_pkg::SIZE_16: ext = {{48{sgn & in_value[15]}}, in_value[15:0]};
            itf_pkg::SIZE_32: ext = {{32{sgn & in_value[31]}}, in_value[31:0]};
            default:          ext = in_value;
        endcase
        negative = sgn && ext[63];
        mag      = negative ? (~ext + 64'd1) : ext;
    end

    // Prefix: sign character, then the alternate-form radix marker.
    always_comb begin
        is_dec = (in_base == itf_pkg::BASE_DEC);
        is_oct = (in_base == itf_pkg::BASE_OCT);
        is_hex = !is_dec && !is_oct;
        alt    = in_flags[itf_pkg::F_ALT];
        xch    = in_flags[itf_pkg::F_UPPER] ? itf_pkg::CH_UX : itf_pkg::CH_LX;
        has_s  = negative || in_flags[itf_pkg::F_PLUS] || in_flags[itf_pkg::F_SPACE];
        if (negative) begin
            sch = itf_pkg::CH_MINUS;
        end else if (in_flags[itf_pkg::F_PLUS]) begin
            sch = itf_pkg::CH_PLUS;
        end else begin
            sch = itf_pkg::CH_SPACE;
        end
        p0 = itf_pkg::CH_SPACE;
        p1 = itf_pkg::CH_SPACE;
        p2 = itf_pkg::CH_SPACE;
        if (has_s) begin
            p0 = sch;
            if (alt && is_hex) begin
                p1 = itf_pkg::CH_ZERO;
                p2 = xch;
            end else if (alt && is_oct) begin
                p1 = itf_pkg::CH_ZERO;
            end
        end else begin
            if (alt && is_hex) begin
                p0 = itf_pkg::CH_ZERO;
                p1 = xch;
            end else if (alt && is_oct) begin
                p0 = itf_pkg::CH_ZERO;
            end
        end
        plen = {1'b0, has_s} + ((alt && is_hex) ? 2'd2 : (alt && is_oct) ? 2'd1 : 2'd0);
    end

    // Octal and hex digits are direct slices of the magnitude.
    logic [itf_pkg::DIG_W-1:0] oct_dig, hex_dig;
    always_comb begin
        oct_dig = '0;
        hex_dig = '0;
        for (int i = 0; i < itf_pkg::DIG_N - 1; i++) begin
            oct_dig[4*i +: 4] = {1'b0, mag[3*i +: 3]};
        end
        oct_dig[itf_pkg::DIG_W-4 +: 4] = {3'b0, mag[63]};
        for (int i = 0; i < 16; i++) begin
            hex_dig[4*i +: 4] = mag[4*i +: 4];
        end
    end

    // One shift-and-add-3 step of the binary to BCD conversion.
    logic [itf_pkg::DIG_W-1:0] adj;
    always_comb begin
        for (int i = 0; i < itf_pkg::DIG_N; i++) begin
            adj[4*i +: 4] = (r_dig[4*i +: 4] >= 4'd5) ? (r_dig[4*i +: 4] + 4'd3)
                                                      : r_dig[4*i +: 4];
        end
    end

    // Current digit during the leading-zero scan.
    logic [3:0] cur;
    assign cur = r_dig[{r_idx, 2'b00} +: 4];

    // Digit and padding counts.
    logic [6:0] nd, cap, prec_eff, ndt, total, wsat, padn;
    always_comb begin
        nd       = {2'b0, r_idx} + 7'd1;
        cap      = 7'(itf_pkg::RESULT_LIMIT) - {5'b0, r_plen};
        prec_eff = (r_prec > cap) ? cap : r_prec;
        ndt      = (!r_prec[6] && (prec_eff > nd)) ? prec_eff : nd;
        total    = {5'b0, r_plen} + ndt;
        wsat     = (r_fw > 7'(itf_pkg::MAX_FIELD_WIDTH)) ? 7'(itf_pkg::MAX_FIELD_WIDTH) : r_fw;
        padn     = (wsat > total) ? (wsat - total) : 7'd0;
    end

    // Character position boundaries.
    logic [6:0] ba, bb, bd, be, bf;
    always_comb begin
        ba = (!r_left && !r_zp) ? r_padn : 7'd0;
        bb = ba + {5'b0, r_plen};
        bd = bb + ((!r_left && r_zp) ? r_padn : 7'd0) + (r_ndt - r_nd);
        be = bd + r_nd;
        bf = be + (r_left ? r_padn : 7'd0);
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sh    = r_sh;
        n_dig   = r_dig;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx = 5'(itf_pkg::DIG_N - 1);
                    n_sh  = mag;
                    n_cnt = 6'd63;
                    if (is_dec) begin
                        n_dig   = '0;
                        n_state = S_CONV;
                    end else begin
                        n_dig   = is_oct ? oct_dig : hex_dig;
                        n_state = S_SCAN;
                    end
                end
            end
            S_CONV: begin
                n_dig = {adj[itf_pkg::DIG_W-2:0], r_sh[63]};
                n_sh  = {r_sh[62:0], 1'b0};
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (cur == 4'd0 && r_idx != 5'd0) begin
                    n_idx = r_idx - 5'd1;
                end else begin
                    n_state = S_FIN1;
                end
            end
            S_FIN1: n_state = S_FIN2;
            S_FIN2: n_state = S_PUSH;
            S_PUSH: begin
                if (i_push_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_sh  <= n_sh;
        r_dig <= n_dig;
        r_idx <= n_idx;
        if (accept) begin
            r_left  <= in_flags[itf_pkg::F_LEFT];
            r_zp    <= in_flags[itf_pkg::F_ZERO];
            r_upper <= in_flags[itf_pkg::F_UPPER];
            r_prec  <= in_prec;
            r_fw    <= in_fw;
            r_plen  <= plen;
            r_p0    <= p0;
            r_p1    <= p1;
            r_p2    <= p2;
        end
        if (r_state == S_FIN1) begin
            r_nd   <= nd;
            r_ndt  <= ndt;
            r_padn <= padn;
        end
        if (r_state == S_FIN2) begin
            r_desc.digits <= r_dig;
            r_desc.p0     <= r_p0;
            r_desc.p1     <= r_p1;
            r_desc.p2     <= r_p2;
            r_desc.upper  <= r_upper;
            r_desc.a      <= ba;
            r_desc.b      <= bb;
            r_desc.d      <= bd;
            r_desc.e      <= be;
            r_desc.f      <= bf;
        end
    end

    assign o_push_valid = (r_state == S_PUSH);
    assign o_push_data  = r_desc;

endmodule

[rtl/itf_queue.sv]
`timescale 1ns / 1ps

module itf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  itf_pkg::t_desc i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output itf_pkg::t_desc o_pop_data
);

    itf_pkg::t_desc r_mem [itf_pkg::QDEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_push_ready = (r_cnt != 2'(itf_pkg::QDEPTH));
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

[rtl/itf_back.sv]
`timescale 1ns / 1ps

module itf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    output logic           o_pop_ready,
    input  itf_pkg::t_desc i_pop_data,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_char,
    output logic           o_last
);

    itf_pkg::t_desc r_desc;
    logic       r_act;
    logic [6:0] r_k;
    logic       r_ov;
    logic [7:0] r_ch;
    logic       r_last;

    logic       load, step, last_now;
    logic [6:0] poff, didx;
    logic [3:0] dig;
    logic [7:0] ch;

    assign o_pop_ready = !r_act;
    assign load        = !r_act && i_pop_valid;
    assign step        = r_act && (!r_ov || i_ready);
    assign last_now    = (r_k == r_desc.f - 7'd1);

    // Character at position r_k of the current conversion.
    always_comb begin
        poff = r_k - r_desc.a;
        didx = r_desc.e - 7'd1 - r_k;
        dig  = r_desc.digits[{didx[4:0], 2'b00} +: 4];
        if (r_k < r_desc.a) begin
            ch = itf_pkg::CH_SPACE;
        end else if (r_k < r_desc.b) begin
            case (poff[1:0])
                2'd0:    ch = r_desc.p0;
                2'd1:    ch = r_desc.p1;
                default: ch = r_desc.p2;
            endcase
        end else if (r_k < r_desc.d) begin
            ch = itf_pkg::CH_ZERO;
        end else if (r_k < r_desc.e) begin
            ch = itf_pkg::digit_char(dig, r_desc.upper);
        end else begin
            ch = itf_pkg::CH_SPACE;
        end
    end

    // Emitter control and output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_ov  <= 1'b0;
            r_k   <= 7'd0;
        end else begin
            if (load) begin
                r_act <= 1'b1;
                r_k   <= 7'd0;
            end else if (step) begin
                r_k <= r_k + 7'd1;
                if (last_now) begin
                    r_act <= 1'b0;
                end
            end
            if (step) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_desc <= i_pop_data;
        end
        if (step) begin
            r_ch   <= ch;
            r_last <= last_now;
        end
    end

    assign o_valid = r_ov;
    assign o_char  = r_ch;
    assign o_last  = r_last;

    // The position counter stays inside the conversion.
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> (r_k < r_desc.f))
        else $error("character position beyond end of conversion");

    // Region boundaries are ordered and at least one digit is present.
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> ((r_desc.a <= r_desc.b) && (r_desc.b <= r_desc.d) &&
                   (r_desc.d < r_desc.e) && (r_desc.e <= r_desc.f)))
        else $error("conversion regions out of order");

    // The final character ends the conversion and is marked in the output.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && last_now) |=> (!r_act && r_ov && r_last))
        else $error("last character did not close the conversion");

endmodule

[rtl/integer_to_text_formatter_unit.sv]
`timescale 1ns / 1ps

// Integer to text formatter: printf-style conversion of one integer argument.
// Input stream (s_*): one transfer carries the value and its conversion
// settings in s_tdata. Output stream (m_*): one ASCII character per transfer,
// with m_tlast high on the final character of each conversion.
// A front end truncates and extends the argument, builds the prefix and the
// digits, then counts leading zeros; a two-entry queue hands the finished
// conversion to an emitter that sends one character per cycle while the
// receiver is ready. In the front end, decimal digits come from a
// shift-and-add-3 conversion and octal or hex digits are direct slices of
// the magnitude; a leading-digit scan follows, then the states S_FIN1 and
// S_FIN2 compute the layout and S_PUSH hands it to the queue.
// A new input transfer is taken only once the front end is idle again, after
// it has handed the previous conversion to the queue.
// The emitter loads a conversion from the queue and then sends its
// characters in order; the front end runs on the next item meanwhile.
// Reset clears all control state; no conversion survives it. When the
// receiver stalls, the held character stays on m_tdata, the emitter waits,
// the queue fills and s_tready drops once the front end cannot hand over.
module integer_to_text_formatter_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // value[63:0], flag_bits[70:64], base_select[72:71], arg_size[74:73],
    // field_width[81:75], precision[88:82], zeros[95:89]
    input  logic [itf_pkg::IN_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // char_out[7:0]
    output logic [7:0]               m_tdata,
    output logic                     m_tlast
);

    logic           push_valid, push_ready, pop_valid, pop_ready;
    itf_pkg::t_desc push_data, pop_data;

    itf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_tvalid),
        .o_ready      (s_tready),
        .i_data       (s_tdata),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    itf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    itf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_valid     (m_tvalid),
        .i_ready     (m_tready),
        .o_char      (m_tdata),
        .o_last      (m_tlast)
    );

endmodule

[sim/itf_text_checker.sv]
`timescale 1ns / 1ps

// Watches both streams of the integer to text formatter. Every input transfer
// is turned into the characters it must produce; every output transfer is
// compared with the oldest character still waiting.
module itf_text_checker
    import itf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_tvalid,
    input  logic            i_in_tready,
    // value[63:0], flag_bits[70:64], base_select[72:71], arg_size[74:73],
    // field_width[81:75], precision[88:82], zeros[95:89]
    input  logic [IN_W-1:0] i_in_tdata,
    input  logic            i_out_tvalid,
    input  logic            i_out_tready,
    // char_out[7:0]
    input  logic [7:0]      i_out_tdata,
    input  logic            i_out_tlast,
    output int              o_fail_count,
    output int              o_pending
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    t_text_char char_expect_q[$];
    int         fail_cnt = 0;

    // Works out the full text of one conversion and queues it character by character.
    function automatic void predict_text(input logic [IN_W-1:0] item);
        logic [63:0] val;
        logic [63:0] mag;
        logic [63:0] mask;
        logic [63:0] radix;
        logic [6:0]  flg;
        logic [6:0]  wid;
        logic [6:0]  prc_raw;
        logic [1:0]  bsel;
        logic [1:0]  asz;
        logic        neg;
        logic        up;
        logic [7:0]  digs [0:63];
        logic [7:0]  pre [0:2];
        logic [7:0]  text [0:63];
        string       tab;
        int          bits;
        int          nd;
        int          plen;
        int          prec;
        int          wmax;
        int          total;
        int          padn;
        int          n;
        int          i;

        val     = item[VALUE_LSB +: 64];
        flg     = item[FLAGS_LSB +: 7];
        bsel    = item[BASE_LSB +: 2];
        asz     = item[SIZE_LSB +: 2];
        wid     = item[WIDTH_LSB +: 7];
        prc_raw = item[PREC_LSB +: 7];
        up      = flg[F_UPPER];
        tab     = up ? "0123456789ABCDEF" : "0123456789abcdef";
        radix   = (bsel == BASE_DEC) ? 64'd10 : (bsel == BASE_OCT) ? 64'd8 : 64'd16;

        // Cut the argument to its size, then sign- or zero-extend it.
        bits = 8 << asz;
        if (bits < 64) begin
            mask = (64'd1 << bits) - 64'd1;
            val  = val & mask;
            if (flg[F_SGN] && val[bits-1]) begin
                val = val | ~mask;
            end
        end
        neg = flg[F_SGN] && val[63];
        mag = neg ? (64'd0 - val) : val;

        // Digits, least significant first; zero still gives one digit.
        nd = 0;
        do begin
            digs[nd] = tab[int'(mag % radix)];
            nd++;
            mag = mag / radix;
        end while (mag != 64'd0);

        // Sign, then the alternate-form marker.
        plen = 0;
        if (neg) begin
            pre[plen] = CH_MINUS;
            plen++;
        end else if (flg[F_PLUS]) begin
            pre[plen] = CH_PLUS;
            plen++;
        end else if (flg[F_SPACE]) begin
            pre[plen] = CH_SPACE;
            plen++;
        end
        if (flg[F_ALT] && bsel != BASE_DEC) begin
            pre[plen] = CH_ZERO;
            plen++;
            if (bsel != BASE_OCT) begin
                pre[plen] = up ? CH_UX : CH_LX;
                plen++;
            end
        end

        // Precision: codes of 64 and above mean none was given.
        prec = (prc_raw >= 7'd64) ? -1 : int'(prc_raw);
        if (prec > RESULT_LIMIT - plen) begin
            prec = RESULT_LIMIT - plen;
        end
        while (nd < prec) begin
            digs[nd] = CH_ZERO;
            nd++;
        end

        // Field width saturates so that the text never exceeds 64 characters.
        wmax = int'(wid);
        if (wmax > MAX_FIELD_WIDTH) begin
            wmax = MAX_FIELD_WIDTH;
        end
        if (wmax > RESULT_LIMIT) begin
            wmax = RESULT_LIMIT;
        end
        total = plen + nd;
        padn  = (wmax > total) ? wmax - total : 0;

        // Lay out the text in emission order.
        n = 0;
        if (!flg[F_LEFT] && !flg[F_ZERO]) begin
            for (i = 0; i < padn; i++) begin
                text[n] = CH_SPACE;
                n++;
            end
        end
        for (i = 0; i < plen; i++) begin
            text[n] = pre[i];
            n++;
        end
        if (!flg[F_LEFT] && flg[F_ZERO]) begin
            for (i = 0; i < padn; i++) begin
                text[n] = CH_ZERO;
                n++;
            end
        end
        for (i = nd - 1; i >= 0; i--) begin
            text[n] = digs[i];
            n++;
        end
        if (flg[F_LEFT]) begin
            for (i = 0; i < padn; i++) begin
                text[n] = CH_SPACE;
                n++;
            end
        end

        for (i = 0; i < n; i++) begin
            char_expect_q.push_back('{ch: text[i], last: (i == n - 1)});
        end
    endfunction

    // Compare each output transfer, then record the text of each input transfer.
    always @(posedge i_clk) begin : watch
        t_text_char want;
        if (i_rst_n) begin
            if (i_out_tvalid && i_out_tready) begin
                if (char_expect_q.size() == 0) begin
                    $error("unexpected character: char_out 0x%02h, last %0b",
                           i_out_tdata, i_out_tlast);
                    fail_cnt++;
                end else begin
                    want = char_expect_q.pop_front();
                    if (want.ch !== i_out_tdata) begin
                        $error("char_out: expected 0x%02h, actual 0x%02h",
                               want.ch, i_out_tdata);
                        fail_cnt++;
                    end
                    if (want.last !== i_out_tlast) begin
                        $error("last: expected %0b, actual %0b", want.last, i_out_tlast);
                        fail_cnt++;
                    end
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                predict_text(i_in_tdata);
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= char_expect_q.size();
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import itf_pkg::*;

    // Codes the package leaves implicit.
    localparam logic [1:0] BASE_HEX   = 2'd2;
    localparam logic [1:0] BASE_SEL3  = 2'd3;
    localparam logic [1:0] SIZE_64    = 2'd3;
    localparam logic [6:0] PREC_NONE  = 7'h7F;

    localparam logic [6:0] FL_ZERO  = 7'(1 << F_ZERO);
    localparam logic [6:0] FL_LEFT  = 7'(1 << F_LEFT);
    localparam logic [6:0] FL_PLUS  = 7'(1 << F_PLUS);
    localparam logic [6:0] FL_BLANK = 7'(1 << F_SPACE);
    localparam logic [6:0] FL_ALT   = 7'(1 << F_ALT);
    localparam logic [6:0] FL_SGN   = 7'(1 << F_SGN);
    localparam logic [6:0] FL_CAPS  = 7'(1 << F_UPPER);

    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES  = 1500;
    localparam int DRAIN_CYCLES = 200;

    logic            i_clk    = 1'b0;
    logic            i_rst_n  = 1'b0;
    logic            s_tvalid = 1'b0;
    logic [IN_W-1:0] s_tdata  = '0;
    logic            m_tready = 1'b0;
    logic            s_tready;
    logic            m_tvalid;
    logic [7:0]      m_tdata;
    logic            m_tlast;

    int   fail_count;
    int   pending;
    int   burst_left = 0;
    logic hold_req   = 1'b0;

    integer_to_text_formatter_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    itf_text_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_tvalid),
        .i_in_tready  (s_tready),
        .i_in_tdata   (s_tdata),
        .i_out_tvalid (m_tvalid),
        .i_out_tready (m_tready),
        .i_out_tdata  (m_tdata),
        .i_out_tlast  (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 50 MHz clock.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // Receiver: segments of differing readiness, and one long hold-off once asked.
    initial begin : rx_pattern
        int   seg;
        int   mode;
        int   k;
        logic hold_done;
        hold_done = 1'b0;
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            seg  = $urandom_range(10, 80);
            mode = $urandom_range(0, 3);
            for (k = 0; k < seg; k++) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (k % 3 != 2);
                endcase
                @(posedge i_clk);
            end
        end
    end

    function automatic logic [IN_W-1:0] pack_item(input logic [63:0] val,
                                                  input logic [6:0]  flg,
                                                  input logic [1:0]  bsel,
                                                  input logic [1:0]  asz,
                                                  input logic [6:0]  wid,
                                                  input logic [6:0]  prc);
        logic [IN_W-1:0] item;
        item = '0;
        item[VALUE_LSB +: 64] = val;
        item[FLAGS_LSB +: 7]  = flg;
        item[BASE_LSB +: 2]   = bsel;
        item[SIZE_LSB +: 2]   = asz;
        item[WIDTH_LSB +: 7]  = wid;
        item[PREC_LSB +: 7]   = prc;
        return item;
    endfunction

    // Offers one conversion; bursts of random length separated by random gaps.
    task automatic send_item(input logic [IN_W-1:0] item);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Random conversion, biased toward short fields and common precisions.
    task automatic send_random();
        logic [63:0] val;
        logic [6:0]  wid;
        logic [6:0]  prc;
        int          r;
        case ($urandom_range(0, 5))
            0: val = 64'($urandom_range(0, 20));
            1: val = $urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
            2: val = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 2));
            default: val = {$urandom, $urandom};
        endcase
        wid = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(0, 24));
        r = $urandom_range(0, 9);
        if (r < 4) begin
            prc = PREC_NONE;
        end else if (r < 8) begin
            prc = 7'($urandom_range(0, 20));
        end else begin
            prc = 7'($urandom);
        end
        send_item(pack_item(val, 7'($urandom), 2'($urandom_range(0, 3)),
                            2'($urandom_range(0, 3)), wid, prc));
    endtask

    // Main sequence: reset, directed cases, random traffic, drain, verdict.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero value: plain, with precision zero, and in alternate form.
        send_item(pack_item(64'd0, 7'd0, BASE_DEC, SIZE_64, 7'd0, PREC_NONE));
        send_item(pack_item(64'd0, 7'd0, BASE_DEC, SIZE_64, 7'd0, 7'd0));
        send_item(pack_item(64'd0, FL_ALT, BASE_HEX, SIZE_32, 7'd0, PREC_NONE));
        send_item(pack_item(64'd0, FL_ALT, BASE_OCT, SIZE_8, 7'd0, 7'd0));
        // Extremes of the argument.
        send_item(pack_item(64'hFFFF_FFFF_FFFF_FFFF, 7'd0, BASE_DEC, SIZE_64, 7'd0, PREC_NONE));
        send_item(pack_item(64'h8000_0000_0000_0000, FL_SGN, BASE_DEC, SIZE_64, 7'd0, PREC_NONE));
        send_item(pack_item(64'hFFFF_FFFF_FFFF_FFFF, FL_ALT, BASE_OCT, SIZE_64, 7'd0, PREC_NONE));
        send_item(pack_item(64'h1234_5678_9ABC_DEF0, FL_ALT | FL_CAPS, BASE_HEX, SIZE_64,
                            7'd0, PREC_NONE));
        // Truncation and sign extension at each size.
        send_item(pack_item(64'h1234_56FF, FL_SGN, BASE_DEC, SIZE_8, 7'd0, PREC_NONE));
        send_item(pack_item(64'hABCD_8000, FL_SGN, BASE_DEC, SIZE_16, 7'd0, PREC_NONE));
        send_item(pack_item(64'h5_8000_0000, FL_SGN, BASE_HEX, SIZE_32, 7'd0, PREC_NONE));
        send_item(pack_item(64'hFFFF_FFFF, 7'd0, BASE_DEC, SIZE_32, 7'd0, PREC_NONE));
        // Sign characters, including on unsigned and negative values.
        send_item(pack_item(64'd42, FL_PLUS, BASE_OCT, SIZE_8, 7'd0, PREC_NONE));
        send_item(pack_item(64'd42, FL_BLANK, BASE_DEC, SIZE_8, 7'd0, PREC_NONE));
        send_item(pack_item(64'd42, FL_PLUS | FL_BLANK, BASE_DEC, SIZE_8, 7'd0, PREC_NONE));
        send_item(pack_item(64'hD6, FL_SGN | FL_PLUS | FL_BLANK, BASE_DEC, SIZE_8, 7'd0,
                            PREC_NONE));
        // Zero padding after the prefix, ignored when left aligned, kept with a precision.
        send_item(pack_item(64'hD6, FL_SGN | FL_ZERO, BASE_DEC, SIZE_8, 7'd10, PREC_NONE));
        send_item(pack_item(64'hBEEF, FL_ZERO | FL_ALT | FL_CAPS | FL_PLUS, BASE_HEX, SIZE_16,
                            7'd12, PREC_NONE));
        send_item(pack_item(64'd7, FL_ZERO | FL_LEFT | FL_BLANK, BASE_DEC, SIZE_8, 7'd9, 7'd3));
        send_item(pack_item(64'd7, FL_ZERO, BASE_OCT, SIZE_16, 7'd11, 7'd4));
        // Radix selector three, width saturation, precision clamping, all flags set.
        send_item(pack_item(64'hCAFE, FL_ALT, BASE_SEL3, SIZE_16, 7'd64, PREC_NONE));
        send_item(pack_item(64'd5, FL_LEFT, BASE_DEC, SIZE_8, 7'd127, PREC_NONE));
        send_item(pack_item(64'hFF, FL_SGN | FL_ALT | FL_PLUS, BASE_HEX, SIZE_8, 7'd0, 7'd61));
        send_item(pack_item(64'd9, FL_ALT | FL_BLANK, BASE_OCT, SIZE_8, 7'd70, 7'd63));
        send_item(pack_item(64'd9, 7'd0, BASE_DEC, SIZE_8, 7'd5, 7'h40));
        send_item(pack_item(64'hFFFF_FFFF_FFFF_FFFF, 7'h7F, BASE_HEX, SIZE_64, 7'd127, 7'd62));

        // Random traffic; the receiver holds off once near the start.
        hold_req = 1'b1;
        repeat (RANDOM_ITEMS) send_random();
        s_tvalid <= 1'b0;

        // Drain, then allow for any stray characters.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/itf_pkg.sv
rtl/itf_front.sv
rtl/itf_queue.sv
rtl/itf_back.sv
rtl/integer_to_text_formatter_unit.sv
sim/itf_text_checker.sv
sim/tb_top.sv
